// ===== src/max_sum_subrectangle_top_defines.svh =====
// Assertion macros for the sub-rectangle search block
`ifndef MAX_SUM_SUBRECTANGLE_TOP_DEFINES_SVH
`define MAX_SUM_SUBRECTANGLE_TOP_DEFINES_SVH

`define MSR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MSR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== src/msr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package msr_pkg;
  localparam int MaxWidth  = 64;
  localparam int MaxHeight = 64;
  localparam int ColW  = $clog2(MaxWidth);
  localparam int RowW  = $clog2(MaxHeight);
  localparam int AddrW = ColW + RowW;
  localparam int PixW  = 17;
  localparam int StripW = 23;
  localparam int SumW  = 29;
  localparam int DimW  = 7;

  localparam logic [1:0] CFG_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_AVERAGE = 2'd2;

  typedef struct packed {
    logic       load;
    logic       clear_best;
    logic       strip_start;
    logic       rd_issue;
    logic       strip_end;
    logic [ColW-1:0] l;
    logic [ColW-1:0] r;
    logic [RowW-1:0] row;
    logic       first_l;
  } ctrl_t;

  function automatic logic [DimW-1:0] eff_dim(input logic [DimW-1:0] v,
                                              input logic [DimW-1:0] maxv);
    logic [DimW-1:0] res;
    begin
      res = v;
      if (v == '0) res = DimW'(1);
      else if (v > maxv) res = maxv;
      return res;
    end
  endfunction
endpackage
`default_nettype wire

// ===== src/max_sum_subrectangle_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Pixels load one per cycle while busy is low and start is high; the last pixel
// of the image starts the search, which for every column pair reads all rows
// through the image memory port, after which the result is shown for one cycle
// on out_valid. The receiver cannot stall; busy falls after out_valid, not with it.
`include "max_sum_subrectangle_top_defines.svh"
module max_sum_subrectangle_top (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic [15:0] in_pixel,
  input  wire logic cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic out_valid,
  output logic signed [28:0] out_best_sum,
  output logic out_found,
  output logic [5:0] out_top_row,
  output logic [5:0] out_bottom_row,
  output logic [5:0] out_left_col,
  output logic [5:0] out_right_col
);
  logic [msr_pkg::DimW-1:0] w_r, h_r, w_eff, h_eff;
  logic [15:0] avg_r;
  logic dim_wr, emit;
  msr_pkg::ctrl_t ctrl;
  logic [msr_pkg::ColW-1:0] ld_col;
  logic [msr_pkg::RowW-1:0] ld_row;

  assign dim_wr = cfg_we && (cfg_index == msr_pkg::CFG_WIDTH ||
                             cfg_index == msr_pkg::CFG_HEIGHT);
  assign w_eff = msr_pkg::eff_dim(w_r, msr_pkg::DimW'(msr_pkg::MaxWidth));
  assign h_eff = msr_pkg::eff_dim(h_r, msr_pkg::DimW'(msr_pkg::MaxHeight));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= msr_pkg::DimW'(msr_pkg::MaxWidth);
      h_r <= msr_pkg::DimW'(msr_pkg::MaxHeight);
      avg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        msr_pkg::CFG_WIDTH:   w_r <= cfg_data[msr_pkg::DimW-1:0];
        msr_pkg::CFG_HEIGHT:  h_r <= cfg_data[msr_pkg::DimW-1:0];
        msr_pkg::CFG_AVERAGE: avg_r <= cfg_data;
        default: ;
      endcase
    end
  end

  msr_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .dim_wr(dim_wr),
    .w_eff(w_eff), .h_eff(h_eff), .busy(busy), .ctrl(ctrl),
    .ld_col(ld_col), .ld_row(ld_row), .emit(emit)
  );

  msr_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .ctrl(ctrl), .ld_col(ld_col), .ld_row(ld_row),
    .pixel(in_pixel), .average(avg_r), .best_sum(out_best_sum),
    .found(out_found), .top_row(out_top_row), .bottom_row(out_bottom_row),
    .left_col(out_left_col), .right_col(out_right_col)
  );

  assign out_valid = emit;

  `MSR_ASSERT_IMP(a_emit_busy, clk, rst_n, out_valid, busy)
  `MSR_ASSERT_NXT(a_emit_frees, clk, rst_n, out_valid, !busy)
  `MSR_ASSERT_IMP(a_found_sum, clk, rst_n, out_valid && !out_found, out_best_sum == '0)
endmodule
`default_nettype wire

// ===== src/msr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msr_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire logic dim_wr,
  input  wire logic [msr_pkg::DimW-1:0] w_eff,
  input  wire logic [msr_pkg::DimW-1:0] h_eff,
  output logic busy,
  output msr_pkg::ctrl_t ctrl,
  output logic [msr_pkg::ColW-1:0] ld_col,
  output logic [msr_pkg::RowW-1:0] ld_row,
  output logic emit
);
  typedef enum logic [1:0] {S_LOAD, S_READ, S_TAIL, S_DONE} state_t;
  state_t state_r, state_nxt;
  logic [msr_pkg::ColW-1:0] lc_r, lc_nxt, l_r, l_nxt, r_r, r_nxt;
  logic [msr_pkg::RowW-1:0] lr_r, lr_nxt, row_r, row_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic last_col, last_row, last_px, last_r, last_l, take;

  assign take     = start && (state_r == S_LOAD);
  assign last_col = ({1'b0, lc_r} == w_eff - 1'b1);
  assign last_row = ({1'b0, lr_r} == h_eff - 1'b1);
  assign last_px  = last_col && last_row;
  assign last_r   = ({1'b0, r_r} == w_eff - 1'b1);
  assign last_l   = ({1'b0, l_r} == w_eff - 1'b1);
  assign busy     = (state_r != S_LOAD);
  assign ld_col   = lc_r;
  assign ld_row   = lr_r;

  always_comb begin
    state_nxt = state_r;
    lc_nxt = lc_r; lr_nxt = lr_r; l_nxt = l_r; r_nxt = r_r; row_nxt = row_r;
    tail_nxt = tail_r;
    ctrl = '0;
    ctrl.l = l_r; ctrl.r = r_r; ctrl.row = row_r;
    ctrl.first_l = (r_r == l_r);
    emit = 1'b0;
    case (state_r)
      S_LOAD: begin
        if (take) begin
          ctrl.load = 1'b1;
          if (last_px) begin
            lc_nxt = '0; lr_nxt = '0;
            l_nxt = '0; r_nxt = '0; row_nxt = '0;
            ctrl.clear_best = 1'b1;
            state_nxt = S_READ;
          end else if (last_col) begin
            lc_nxt = '0; lr_nxt = lr_r + 1'b1;
          end else begin
            lc_nxt = lc_r + 1'b1;
          end
        end
      end
      S_READ: begin
        ctrl.rd_issue = 1'b1;
        ctrl.strip_start = (row_r == '0);
        if ({1'b0, row_r} == h_eff - 1'b1) begin
          row_nxt = '0;
          tail_nxt = 2'd0;
          state_nxt = S_TAIL;
        end else begin
          row_nxt = row_r + 1'b1;
        end
      end
      S_TAIL: begin
        // drain read and scan stages
        tail_nxt = tail_r + 1'b1;
        if (tail_r == 2'd2) begin
          ctrl.strip_end = 1'b1;
          if (last_r) begin
            if (last_l) begin
              state_nxt = S_DONE;
            end else begin
              l_nxt = l_r + 1'b1; r_nxt = l_r + 1'b1;
              state_nxt = S_READ;
            end
          end else begin
            r_nxt = r_r + 1'b1;
            state_nxt = S_READ;
          end
        end
      end
      S_DONE: begin
        emit = 1'b1;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
    if (dim_wr) begin
      lc_nxt = '0; lr_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      lc_r <= '0; lr_r <= '0; l_r <= '0; r_r <= '0; row_r <= '0;
      tail_r <= '0;
    end else begin
      state_r <= state_nxt;
      lc_r <= lc_nxt; lr_r <= lr_nxt; l_r <= l_nxt; r_r <= r_nxt;
      row_r <= row_nxt; tail_r <= tail_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== src/msr_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module msr_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire msr_pkg::ctrl_t ctrl,
  input  wire logic [msr_pkg::ColW-1:0] ld_col,
  input  wire logic [msr_pkg::RowW-1:0] ld_row,
  input  wire logic [15:0] pixel,
  input  wire logic [15:0] average,
  output logic signed [msr_pkg::SumW-1:0] best_sum,
  output logic found,
  output logic [5:0] top_row,
  output logic [5:0] bottom_row,
  output logic [5:0] left_col,
  output logic [5:0] right_col
);
  localparam int ColW = msr_pkg::ColW;
  localparam int RowW = msr_pkg::RowW;
  logic signed [msr_pkg::PixW-1:0] mem [msr_pkg::MaxWidth*msr_pkg::MaxHeight];
  logic signed [msr_pkg::StripW-1:0] strip [msr_pkg::MaxHeight];
  logic signed [msr_pkg::PixW-1:0] rd_r;
  logic signed [msr_pkg::StripW-1:0] sold_r;
  logic v1_r, v2_r, first_r, st1_r, st2_r;
  logic [RowW-1:0] row1_r, row2_r;
  logic signed [msr_pkg::StripW-1:0] snew_r;
  logic signed [msr_pkg::SumW-1:0] run_r, sbest_r, run_sum, bsum_r;
  logic [RowW-1:0] rstart_r, stop_r, sbot_r;
  logic sfound_r, bfound_r;
  logic [RowW-1:0] btop_r, bbot_r;
  logic [ColW-1:0] bl_r, br_r;
  logic signed [msr_pkg::StripW-1:0] snew;
  logic signed [msr_pkg::SumW-1:0] run_base;
  logic signed [msr_pkg::SumW-1:0] sbest_base;
  logic sfound_base;
  logic [RowW-1:0] rstart_base;

  always_ff @(posedge clk) begin
    if (ctrl.load)
      mem[{ld_row, ld_col}] <= $signed({1'b0, pixel}) - $signed({1'b0, average});
    if (ctrl.rd_issue) begin
      rd_r   <= mem[{ctrl.row, ctrl.r}];
      sold_r <= strip[ctrl.row];
    end
    first_r <= ctrl.first_l;
    row1_r  <= ctrl.row;
    st1_r   <= ctrl.strip_start;
    row2_r  <= row1_r;
    st2_r   <= st1_r;
    snew_r  <= snew;
    if (v1_r) strip[row1_r] <= snew;
  end

  assign snew = first_r ? msr_pkg::StripW'(rd_r)
                        : sold_r + msr_pkg::StripW'(rd_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0;
    end else begin
      v1_r <= ctrl.rd_issue;
      v2_r <= v1_r;
    end
  end

  // first row of a strip starts the scan afresh
  assign run_base    = st2_r ? '0 : run_r;
  assign sbest_base  = st2_r ? '0 : sbest_r;
  assign sfound_base = st2_r ? 1'b0 : sfound_r;
  assign rstart_base = st2_r ? '0 : rstart_r;
  assign run_sum     = run_base + msr_pkg::SumW'(snew_r);

  always_ff @(posedge clk) begin
    if (v2_r) begin
      if (run_sum > sbest_base) begin
        run_r <= run_sum; sbest_r <= run_sum; sfound_r <= 1'b1;
        stop_r <= rstart_base; sbot_r <= row2_r;
        rstart_r <= rstart_base;
      end else if (run_sum < 0) begin
        run_r <= '0; rstart_r <= row2_r + 1'b1;
        sbest_r <= sbest_base; sfound_r <= sfound_base;
      end else begin
        run_r <= run_sum; rstart_r <= rstart_base;
        sbest_r <= sbest_base; sfound_r <= sfound_base;
      end
    end
    if (ctrl.clear_best) begin
      bsum_r <= '0; bfound_r <= 1'b0; btop_r <= '0; bbot_r <= '0;
      bl_r <= '0; br_r <= '0;
    end else if (ctrl.strip_end && sfound_r && sbest_r > bsum_r) begin
      bsum_r <= sbest_r; bfound_r <= 1'b1; btop_r <= stop_r; bbot_r <= sbot_r;
      bl_r <= ctrl.l; br_r <= ctrl.r;
    end
  end

  assign best_sum   = bsum_r;
  assign found      = bfound_r;
  assign top_row    = 6'(btop_r);
  assign bottom_row = 6'(bbot_r);
  assign left_col   = 6'(bl_r);
  assign right_col  = 6'(br_r);
endmodule
`default_nettype wire
